// File: sv/lk3_pkg.sv
// Shared types, constants and round functions for the lookup3 key hash.
package lk3_pkg;

	// Default number of significant bits of the key length.
	localparam int LK3_LENGTH_BITS = 16;

	// Width of the key length field on the input stream.
	localparam int KEY_LEN_W = 16;

	// Width of a key word and of the hash state words.
	localparam int WORD_W = 32;

	// Start value of a, b and c before the key length is added.
	localparam logic [WORD_W-1:0] LK3_SEED = 32'(32'hdeadbeef + 32'h003bdc96);

	// The three hash state words.
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
	} lk3_abc_t;

	// Request to the final round pipeline; bypass passes c through unmixed.
	typedef struct packed {
		logic     bypass;
		lk3_abc_t st;
	} lk3_fin_t;

	// Which state word the next key word is added to.
	typedef enum logic [1:0] {
		SLOT_A = 2'd0,
		SLOT_B = 2'd1,
		SLOT_C = 2'd2
	} lk3_slot_t;

	// Rotate left by a constant amount.
	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// Mix round applied after each full 12-byte block that does not end the key.
	function automatic lk3_abc_t mix3(input lk3_abc_t s);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		a = s.a;
		b = s.b;
		c = s.c;
		a = a - c; a = a ^ rotl32(c, 4);  c = c + b;
		b = b - a; b = b ^ rotl32(a, 6);  a = a + c;
		c = c - b; c = c ^ rotl32(b, 8);  b = b + a;
		a = a - c; a = a ^ rotl32(c, 16); c = c + b;
		b = b - a; b = b ^ rotl32(a, 19); a = a + c;
		c = c - b; c = c ^ rotl32(b, 4);  b = b + a;
		return '{a: a, b: b, c: c};
	endfunction

	// First four steps of the final round.
	function automatic lk3_abc_t final_head(input lk3_abc_t s);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		a = s.a;
		b = s.b;
		c = s.c;
		c = c ^ b; c = c - rotl32(b, 14);
		a = a ^ c; a = a - rotl32(c, 11);
		b = b ^ a; b = b - rotl32(a, 25);
		c = c ^ b; c = c - rotl32(b, 16);
		return '{a: a, b: b, c: c};
	endfunction

	// Last three steps of the final round; c is the hash.
	function automatic logic [WORD_W-1:0] final_tail(input lk3_abc_t s);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		a = s.a;
		b = s.b;
		c = s.c;
		a = a ^ c; a = a - rotl32(c, 4);
		b = b ^ a; b = b - rotl32(a, 14);
		c = c ^ b; c = c - rotl32(b, 24);
		return c;
	endfunction

endpackage

// File: sv/lk3_final.sv
// Two-stage final round pipeline with the result output register.
module lk3_final import lk3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lk3_fin_t          in_req,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata
);

	logic     valid_s2;
	logic     valid_s3;
	lk3_fin_t req_s2;
	lk3_fin_t req_s3;
	logic     out_ready;
	logic     s3_ready;

	// Each stage moves when the stage after it is empty or moving.
	assign out_ready = !m_tvalid || m_tready;
	assign s3_ready  = !valid_s3 || out_ready;
	assign in_ready  = !valid_s2 || s3_ready;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (in_ready) valid_s2 <= in_valid;
			if (s3_ready) valid_s3 <= valid_s2;
			if (out_ready) m_tvalid <= valid_s3;
		end
	end

	// Stage data: first half of the final round, then the second half.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) req_s2 <= in_req;
		if (s3_ready && valid_s2) begin
			req_s3.bypass <= req_s2.bypass;
			req_s3.st     <= req_s2.bypass ? req_s2.st : final_head(req_s2.st);
		end
		if (out_ready && valid_s3) begin
			m_tdata <= req_s3.bypass ? req_s3.st.c : final_tail(req_s3.st);
		end
	end

endmodule

// File: sv/lookup3_key_hash.sv
// Lookup3 key hash: word stream in, one 32-bit hash per completed key out.
//
// The block hashes a byte key with the lookup3 little-endian scheme. Each
// input transfer carries one 32-bit key word, earliest byte in the low bits;
// the key length in bytes is taken from the first word of a key and ignored
// on the words that follow. Bytes past the end of the key are masked off.
// One word is accepted every clock cycle while the result side keeps up; the
// 12-byte block mix is done in the same cycle as the word that completes the
// block, so the accumulator loop never stalls the input. The hash of a key
// is computed through a two-stage final round pipeline and
// the output register. A key of length zero takes one word and returns the
// initial value unmixed. Backpressure on the result side stalls the input
// only once all pipeline stages are full.
module lookup3_key_hash import lk3_pkg::*; #(
	parameter int LENGTH_BITS = LK3_LENGTH_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [KEY_LEN_W+31:0]   s_tdata,  // key_word [31:0], key_length [47:32]
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [WORD_W-1:0]       m_tdata   // hash_value [31:0]
);

	// Significant length bits, never more than the field carries.
	localparam int LenW = (LENGTH_BITS < KEY_LEN_W) ? LENGTH_BITS : KEY_LEN_W;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic [LenW-1:0]   len_s1;

	logic              busy_q;
	logic [LenW-1:0]   left_q;
	lk3_slot_t         slot_q;
	lk3_abc_t          st_q;

	logic              fin_ready;
	logic              fin_valid;
	lk3_fin_t          fin_req;
	logic              s1_fire;

	logic [WORD_W-1:0] init;
	logic              zero_key;
	lk3_abc_t          st_in;
	lk3_abc_t          st_add;
	logic [LenW-1:0]   left_in;
	logic [LenW-1:0]   left_next;
	lk3_slot_t         slot_in;
	lk3_slot_t         slot_next;
	logic [WORD_W-1:0] word_m;
	logic              last_word;

	assign s1_fire  = valid_s1 && fin_ready;
	assign s_tready = !valid_s1 || fin_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1 <= s_tdata[WORD_W-1:0];
			len_s1  <= s_tdata[WORD_W +: LenW];
		end
	end

	// One key word: start a key if idle, mask, accumulate, decide next step.
	always_comb begin
		init      = LK3_SEED + WORD_W'(len_s1);
		st_in     = st_q;
		left_in   = left_q;
		slot_in   = slot_q;
		if (!busy_q) begin
			st_in   = '{a: init, b: init, c: init};
			left_in = len_s1;
			slot_in = SLOT_A;
		end
		zero_key = !busy_q && (len_s1 == '0);

		// Keep only the bytes that remain in the key.
		word_m = word_s1;
		if (left_in < LenW'(4)) begin
			case (left_in[1:0])
				2'd1:    word_m = {24'd0, word_s1[7:0]};
				2'd2:    word_m = {16'd0, word_s1[15:0]};
				2'd3:    word_m = {8'd0, word_s1[23:0]};
				default: word_m = '0;
			endcase
			left_next = '0;
		end else begin
			left_next = left_in - LenW'(4);
		end

		st_add = st_in;
		case (slot_in)
			SLOT_A:  st_add.a = st_in.a + word_m;
			SLOT_B:  st_add.b = st_in.b + word_m;
			default: st_add.c = st_in.c + word_m;
		endcase

		case (slot_in)
			SLOT_A:  slot_next = SLOT_B;
			SLOT_B:  slot_next = SLOT_C;
			default: slot_next = SLOT_A;
		endcase

		last_word      = (left_next == '0);
		fin_req.bypass = zero_key;
		fin_req.st     = st_add;
		fin_valid      = valid_s1 && (zero_key || last_word);
	end

	// Key control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
			slot_q <= SLOT_A;
		end else if (s1_fire && !zero_key) begin
			if (last_word) begin
				busy_q <= 1'b0;
				slot_q <= SLOT_A;
			end else begin
				busy_q <= 1'b1;
				left_q <= left_next;
				slot_q <= slot_next;
			end
		end
	end

	// Hash state, mixed after the third word of each block that does not end the key.
	always_ff @(posedge clk) begin
		if (s1_fire && !zero_key && !last_word) begin
			st_q <= (slot_in == SLOT_C) ? mix3(st_add) : st_add;
		end
	end

	lk3_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fin_valid),
		.in_ready (fin_ready),
		.in_req   (fin_req),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: sv/lk3_checker.sv
// Port-level checks for the lookup3 key hash, bound to the top level.
module lk3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A result waiting for the sink stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transfer withdrawn while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// No result is offered while reset is applied.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result offered during reset");

	// Out of reset the input is open and the result side stays idle while the pipeline is still empty.
	a_reset_latency: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> s_tready && !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
		else $error("result appeared too early after reset");

endmodule

bind lookup3_key_hash lk3_checker u_lk3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/tb_lookup3_key_hash.sv
// Testbench for the lookup3 key hash: random and directed keys checked against a predictor.
`timescale 1ns / 100ps

module tb_lookup3_key_hash;
	import lk3_pkg::*;

	// Expected hashes for accepted key words, with the hash state they are computed from.
	class key_hash_scoreboard;
		localparam logic [WORD_W-1:0] HASH_START = 32'hdeadbeef + 32'h003bdc96;
		localparam logic [KEY_LEN_W-1:0] LEN_MASK = KEY_LEN_W'((64'd1 << LK3_LENGTH_BITS) - 1);

		bit                   in_key;
		logic [KEY_LEN_W-1:0] bytes_todo;
		lk3_slot_t            slot;
		logic [WORD_W-1:0]    ha;
		logic [WORD_W-1:0]    hb;
		logic [WORD_W-1:0]    hc;
		logic [WORD_W-1:0]    hashes_due[$];
		int unsigned          errors;

		function new();
			in_key = 1'b0;
			bytes_todo = '0;
			slot = SLOT_A;
			ha = '0;
			hb = '0;
			hc = '0;
			errors = 0;
		endfunction

		function logic [WORD_W-1:0] rot(logic [WORD_W-1:0] v, int n);
			return (v << n) | (v >> (WORD_W - n));
		endfunction

		// Block mix after every full 12 bytes that is not the end of the key.
		function void mix_block();
			logic [WORD_W-1:0] a;
			logic [WORD_W-1:0] b;
			logic [WORD_W-1:0] c;
			a = ha;
			b = hb;
			c = hc;
			a -= c; a ^= rot(c, 4);  c += b;
			b -= a; b ^= rot(a, 6);  a += c;
			c -= b; c ^= rot(b, 8);  b += a;
			a -= c; a ^= rot(c, 16); c += b;
			b -= a; b ^= rot(a, 19); a += c;
			c -= b; c ^= rot(b, 4);  b += a;
			ha = a;
			hb = b;
			hc = c;
		endfunction

		function logic [WORD_W-1:0] final_c();
			logic [WORD_W-1:0] a;
			logic [WORD_W-1:0] b;
			logic [WORD_W-1:0] c;
			a = ha;
			b = hb;
			c = hc;
			c ^= b; c -= rot(b, 14);
			a ^= c; a -= rot(c, 11);
			b ^= a; b -= rot(a, 25);
			c ^= b; c -= rot(b, 16);
			a ^= c; a -= rot(c, 4);
			b ^= a; b -= rot(a, 14);
			c ^= b; c -= rot(b, 24);
			return c;
		endfunction

		// Called for each accepted key word; queues a hash when the key completes.
		function void note_word(logic [WORD_W-1:0] w, logic [KEY_LEN_W-1:0] l);
			logic [WORD_W-1:0]    start;
			logic [WORD_W-1:0]    add;
			logic [KEY_LEN_W-1:0] len;
			int unsigned          take;
			if (!in_key) begin
				len = l & LEN_MASK;
				start = HASH_START + WORD_W'(len);
				ha = start;
				hb = start;
				hc = start;
				slot = SLOT_A;
				bytes_todo = len;
				// An empty key returns the start value and leaves the block idle.
				if (len == 0) begin
					hashes_due.push_back(start);
					return;
				end
				in_key = 1'b1;
			end
			take = (bytes_todo < 4) ? bytes_todo : 4;
			add = w;
			if (take < 4)
				add = w & ((32'h1 << (8 * take)) - 32'h1);
			case (slot)
				SLOT_A: ha += add;
				SLOT_B: hb += add;
				default: hc += add;
			endcase
			bytes_todo -= KEY_LEN_W'(take);
			if (bytes_todo == 0) begin
				hashes_due.push_back(final_c());
				in_key = 1'b0;
				slot = SLOT_A;
			end else begin
				case (slot)
					SLOT_A: slot = SLOT_B;
					SLOT_B: slot = SLOT_C;
					default: begin
						mix_block();
						slot = SLOT_A;
					end
				endcase
			end
		endfunction

		// Called for each accepted hash; compares it with the oldest one due.
		function void check_hash(logic [WORD_W-1:0] h);
			logic [WORD_W-1:0] want;
			if (hashes_due.size() == 0) begin
				$display("%0t: unexpected hash %08h, none expected", $time, h);
				errors++;
				return;
			end
			want = hashes_due.pop_front();
			if (h !== want) begin
				$display("%0t: hash mismatch, expected %08h, actual %08h", $time, want, h);
				errors++;
			end
		endfunction

		function int outstanding();
			return hashes_due.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [KEY_LEN_W+31:0] s_tdata;  // key_word [31:0], key_length [47:32]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [WORD_W-1:0]     m_tdata;  // hash_value [31:0]

	key_hash_scoreboard sb;
	bit                 quiet;
	bit                 long_hold;
	int                 words_sent;

	lookup3_key_hash u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#20000000;
		$display("tb_lookup3_key_hash failed");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (60) @(negedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check every hash transfer.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_hash(m_tdata);
	end

	// Offer one key word, with an occasional gap first; returns at the next falling edge.
	task automatic send_word(input logic [31:0] w, input logic [KEY_LEN_W-1:0] l);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tdata <= {l, w};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_word(w, l);
		words_sent++;
		@(negedge clk);
	endtask

	// Send a whole key; fill selects random, all-ones or all-zero words.
	task automatic send_key(input int len, input int fill);
		int          nwords;
		logic [31:0] w;
		nwords = (len == 0) ? 1 : (len + 3) / 4;
		for (int i = 0; i < nwords; i++) begin
			case (fill)
				1: w = 32'hffffffff;
				2: w = 32'h0;
				default: w = $urandom;
			endcase
			// The length field only counts on the first word of a key.
			send_word(w, (i == 0) ? KEY_LEN_W'(len) : KEY_LEN_W'($urandom));
		end
	endtask

	// Stop offering words until every hash due has come out.
	task automatic wait_hashes_out();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Reset, stimulus and final verdict.
	initial begin
		int base;
		int len;
		int pick;
		sb = new();
		quiet = 1'b0;
		long_hold = 1'b0;
		words_sent = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed keys: empty keys, masking of partial words, block boundaries.
		send_key(0, 1);
		send_key(0, 2);
		send_key(1, 1);
		send_key(2, 1);
		send_key(3, 1);
		send_key(4, 1);
		send_key(4, 2);
		send_key(5, 1);
		send_key(8, 0);
		send_key(12, 0);
		send_key(13, 1);

		// Hold the result side off while empty keys keep coming, so the input stalls.
		long_hold = 1'b1;
		for (int i = 0; i < 20; i++)
			send_key(0, 0);
		wait_hashes_out();

		// A longer key that runs through many block mixes.
		send_key(301, 0);

		// Random keys, mostly short; no idling toward the end.
		base = words_sent;
		while (words_sent - base < 300) begin
			if (words_sent - base > 240)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				len = 0;
			else if (pick < 80)
				len = $urandom_range(1, 40);
			else
				len = $urandom_range(41, 200);
			send_key(len, (pick % 17 == 0) ? 1 : 0);
		end

		wait_hashes_out();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("tb_lookup3_key_hash passed");
		end else begin
			$display("tb_lookup3_key_hash failed");
		end
		$finish;
	end

endmodule
